FILE: sv/sla_pkg.sv
// shared types and constants for the sound level alarm detector
// no dependencies
package sla_pkg;

    localparam int LEVEL_W       = 16;
    localparam int THR_W         = 15;
    localparam int ACNT_W        = 4;
    localparam int LOUD_OUT_W    = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int WARMUP_W      = 3;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 24;

    localparam logic [WARMUP_W-1:0] WARMUP_FRAMES = 3'd4;

    localparam logic signed [LEVEL_W-1:0] FLOOR_QUIET = 16'sd13824;
    localparam logic signed [LEVEL_W-1:0] FLOOR_LOUD  = 16'sd14080;
    localparam logic signed [LEVEL_W-1:0] AVG_SPLIT   = 16'sd12800;

    localparam logic [THR_W-1:0]  ENV_THR_RESET   = 15'd1280;
    localparam logic [THR_W-1:0]  NOISE_OFF_RESET = 15'd1280;
    localparam logic [ACNT_W-1:0] ALARM_CNT_RESET = 4'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENV_THRESHOLD = 2'd0,
        REG_NOISE_OFFSET  = 2'd1,
        REG_ALARM_COUNT   = 2'd2
    } reg_index_t;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIVGO = 6'b000010,
        S_DIV   = 6'b000100,
        S_PUSH  = 6'b001000,
        S_SCAN  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

endpackage

FILE: sv/sla_ram.sv
// generic single write port ram with one registered read port
// no dependencies
module sla_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 15,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/sla_div.sv
// restoring divider, one quotient bit per cycle, result truncated toward zero
// no dependencies
module sla_div #(
    parameter int DIVIDEND_W = 40,
    parameter int DIVISOR_W  = 24,
    parameter int QUOT_W     = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [DIVIDEND_W-1:0] dividend,
    input  logic        [DIVISOR_W-1:0]  divisor,
    output logic                         busy,
    output logic                         done,
    output logic signed [QUOT_W-1:0]     quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] mag_reg,  mag_next;
    logic [DIVISOR_W-1:0]  rem_reg,  rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg,  dsr_next;
    logic                  neg_reg,  neg_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    diff;

    always_comb begin
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, mag_reg[DIVIDEND_W-1]};
        diff      = rem_sh - {1'b0, dsr_reg};
        if (start) begin
            neg_next  = dividend[DIVIDEND_W-1];
            mag_next  = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
            rem_next  = '0;
            dsr_next  = divisor;
            step_next = STEP_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[DIVISOR_W]) begin
                rem_next = diff[DIVISOR_W-1:0];
                mag_next = {mag_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[DIVISOR_W-1:0];
                mag_next = {mag_reg[DIVIDEND_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? QUOT_W'(-mag_reg[QUOT_W-1:0]) : QUOT_W'(mag_reg[QUOT_W-1:0]);

endmodule

FILE: sv/sound_level_alarm_detector_core.sv
// sound level alarm detector: top level with control sequencer and level window
// depends on sla_pkg, sla_ram and sla_div
//
// usage
//   s_ side takes one word per audio frame: the frame level in dB, signed Q8.8.
//   m_ side returns one word per input word: alarm flag, background average and
//   the number of loud window entries. the cfg_ port writes the three registers
//   (0 rise threshold, 1 noise margin, 2 alarm count); the user must write them
//   only while the block is idle, the block itself does not enforce it. for the
//   four warm-up frames the word goes straight to the output step. after that,
//   when the level joins the background average, the divider runs first (one
//   quotient bit per cycle); then the level is pushed into the window, and the
//   window scan reads one ram entry per cycle. one word in flight at a time.
//   the output register holds a finished result while m_tready is low; the next
//   word is taken meanwhile and waits in the last step until the register frees.
//   reset is synchronous active low: registers go to their reset values, the
//   window is empty and the averaging starts again from zero.
module sound_level_alarm_detector_core #(
    parameter int WINDOW_DEPTH   = 15,
    parameter int BG_COUNT_WIDTH = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sla_pkg::S_TDATA_W-1:0]     s_tdata,    // level_db
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sla_pkg::M_TDATA_W-1:0]     m_tdata,    // alarm, background_level, loud_entries
    input  logic                              cfg_we,
    input  logic [sla_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sla_pkg::THR_W-1:0]         cfg_wdata
);

    import sla_pkg::*;

    localparam int AW     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FW     = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = LEVEL_W + BG_COUNT_WIDTH;
    localparam int LOUD_W = FW;
    localparam int MRG_W  = LEVEL_W + 2;

    state_t                       state_reg, state_next;
    logic [WARMUP_W-1:0]          warm_cnt_reg, warm_cnt_next;
    logic signed [LEVEL_W-1:0]    prev_reg, prev_next;
    logic signed [SUM_W-1:0]      sum_reg, sum_next;
    logic [BG_COUNT_WIDTH-1:0]    count_reg, count_next;
    logic signed [LEVEL_W-1:0]    avg_reg, avg_next;
    logic [AW-1:0]                head_reg, head_next;
    logic [FW-1:0]                fill_reg, fill_next;
    logic [FW-1:0]                rd_idx_reg, rd_idx_next;
    logic                         pend_reg, pend_next;
    logic [LOUD_W-1:0]            loud_reg, loud_next;
    logic                         warm_reg, warm_next;
    logic [THR_W-1:0]             env_thr_reg;
    logic [THR_W-1:0]             noise_off_reg;
    logic [ACNT_W-1:0]            alarm_cnt_reg;
    logic                         m_valid_reg, m_valid_next;
    logic signed [LEVEL_W-1:0]    level_reg, level_next;
    logic signed [MRG_W-1:0]      margin_reg, margin_next;
    logic signed [LEVEL_W-1:0]    floor_reg, floor_next;
    logic                         alarm_out_reg;
    logic [LEVEL_W-1:0]           bg_out_reg;
    logic [LOUD_OUT_W-1:0]        loud_out_reg;

    logic                         in_acc;
    logic                         out_free;
    logic signed [LEVEL_W-1:0]    s_level;
    logic signed [LEVEL_W:0]      rise;
    logic                         qualifies;
    logic                         div_start;
    logic                         div_busy;
    logic                         div_done;
    logic signed [LEVEL_W-1:0]    div_quot;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [AW-1:0]                ram_raddr;
    logic [LEVEL_W-1:0]           ram_rdata;
    logic [AW:0]                  push_sum;
    logic [AW:0]                  rd_sum;
    logic signed [LEVEL_W-1:0]    entry;
    logic                         entry_loud;
    logic [LOUD_W+3:0]            loud_ext;
    logic                         alarm_now;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign s_level   = $signed(s_tdata[LEVEL_W-1:0]);
    assign rise      = (LEVEL_W+1)'(s_level) - (LEVEL_W+1)'(prev_reg);
    assign qualifies = (rise < $signed({2'b00, env_thr_reg})) && !(&count_reg);
    assign div_start = (state_reg == S_DIVGO);

    assign push_sum  = (AW+1)'(head_reg) + (AW+1)'(fill_reg);
    assign rd_sum    = (AW+1)'(head_reg) + (AW+1)'(rd_idx_reg);
    assign ram_waddr = (push_sum >= (AW+1)'(WINDOW_DEPTH)) ?
                       AW'(push_sum - (AW+1)'(WINDOW_DEPTH)) : AW'(push_sum);
    assign ram_raddr = (rd_sum >= (AW+1)'(WINDOW_DEPTH)) ?
                       AW'(rd_sum - (AW+1)'(WINDOW_DEPTH)) : AW'(rd_sum);
    assign ram_we    = (state_reg == S_PUSH);

    assign entry      = $signed(ram_rdata);
    assign entry_loud = (MRG_W'(entry) > margin_reg) && (entry > floor_reg);
    assign loud_ext   = (LOUD_W+4)'(loud_reg);
    assign alarm_now  = !warm_reg && (loud_ext >= (LOUD_W+4)'(alarm_cnt_reg));

    sla_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_window (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (level_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sla_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (BG_COUNT_WIDTH),
        .QUOT_W     (LEVEL_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb begin
        state_next    = state_reg;
        warm_cnt_next = warm_cnt_reg;
        prev_next     = prev_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        avg_next      = avg_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = 1'b0;
        loud_next     = loud_reg;
        warm_next     = warm_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        level_next    = level_reg;
        margin_next   = margin_reg;
        floor_next    = floor_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    level_next = s_level;
                    prev_next  = s_level;
                    if (warm_cnt_reg < WARMUP_FRAMES) begin
                        warm_cnt_next = warm_cnt_reg + 1'b1;
                        warm_next     = 1'b1;
                        loud_next     = '0;
                        state_next    = S_OUT;
                    end else begin
                        warm_next = 1'b0;
                        if (qualifies) begin
                            count_next = count_reg + 1'b1;
                            sum_next   = sum_reg + SUM_W'(s_level);
                            state_next = S_DIVGO;
                        end else begin
                            state_next = S_PUSH;
                        end
                    end
                end
            end
            S_DIVGO: begin
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    avg_next   = div_quot;
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                if (fill_reg == FW'(WINDOW_DEPTH)) begin
                    head_next = (head_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                end else begin
                    fill_next = fill_reg + 1'b1;
                end
                margin_next = MRG_W'(avg_reg) + MRG_W'({1'b0, noise_off_reg});
                floor_next  = (avg_reg < AVG_SPLIT) ? FLOOR_QUIET : FLOOR_LOUD;
                rd_idx_next = '0;
                loud_next   = '0;
                state_next  = S_SCAN;
            end
            S_SCAN: begin
                if (rd_idx_reg != fill_reg) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                if (pend_reg && entry_loud) begin
                    loud_next = loud_reg + 1'b1;
                end
                if (rd_idx_reg == fill_reg && !pend_reg) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (alarm_now) begin
                        fill_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            warm_cnt_reg  <= '0;
            prev_reg      <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            avg_reg       <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            loud_reg      <= '0;
            warm_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            env_thr_reg   <= ENV_THR_RESET;
            noise_off_reg <= NOISE_OFF_RESET;
            alarm_cnt_reg <= ALARM_CNT_RESET;
        end else begin
            state_reg    <= state_next;
            warm_cnt_reg <= warm_cnt_next;
            prev_reg     <= prev_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            avg_reg      <= avg_next;
            head_reg     <= head_next;
            fill_reg     <= fill_next;
            rd_idx_reg   <= rd_idx_next;
            pend_reg     <= pend_next;
            loud_reg     <= loud_next;
            warm_reg     <= warm_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_ENV_THRESHOLD: env_thr_reg   <= cfg_wdata;
                    REG_NOISE_OFFSET:  noise_off_reg <= cfg_wdata;
                    REG_ALARM_COUNT:   alarm_cnt_reg <= cfg_wdata[ACNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        level_reg  <= level_next;
        margin_reg <= margin_next;
        floor_reg  <= floor_next;
        if (state_reg == S_OUT && out_free) begin
            alarm_out_reg <= alarm_now;
            bg_out_reg    <= avg_reg;
            loud_out_reg  <= (loud_ext > (LOUD_W+4)'(15)) ? 4'hF : loud_ext[LOUD_OUT_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, loud_out_reg, bg_out_reg, alarm_out_reg};

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(WINDOW_DEPTH))
        else $error("window fill beyond depth");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_tready)
        else $error("second word taken while one is in flight");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_alarm_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && out_free && alarm_now) |=> (fill_reg == '0 && m_tdata[0]))
        else $error("alarm did not empty the window");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for sound_level_alarm_detector_core: directed frame levels,
// then scene-like random traffic under several register settings and handshake stalls
// depends on sla_pkg and the rtl of the block, checks every result word in order
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sla_pkg::*;

    localparam int WINDOW_DEPTH     = 15;
    localparam int BG_COUNT_WIDTH   = 24;
    localparam longint BG_COUNT_MAX = (longint'(1) << BG_COUNT_WIDTH) - 1;
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int SETTLE_CYCLES    = 80;
    localparam int SCENE_PHASES     = 8;
    localparam int FRAMES_PER_PHASE = 194;
    localparam int REPORT_MAX       = 10;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [LOUD_OUT_W-1:0]      loud;
        logic signed [LEVEL_W-1:0]  bg;
        logic                       alarm;
    } verdict_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [THR_W-1:0]       cfg_wdata;

    // predictor state
    logic [WARMUP_W-1:0]        frames_seen;
    logic signed [LEVEL_W-1:0]  last_level;
    longint                     bg_sum;
    longint                     bg_frames;
    logic signed [LEVEL_W-1:0]  bg_avg;
    logic signed [LEVEL_W-1:0]  history [WINDOW_DEPTH];
    int                         history_fill;
    logic [THR_W-1:0]           rise_limit;
    logic [THR_W-1:0]           loud_margin;
    logic [ACNT_W-1:0]          loud_needed;

    verdict_t pending_verdicts [$];

    int cycles;
    int mismatches;
    int frames_sent;
    int alarms_seen;
    int loud_frames;
    int settings_used;
    int send_gap_pct;
    int stall_pct;
    int scene_base;
    int burst_left;

    sound_level_alarm_detector_core #(
        .WINDOW_DEPTH   (WINDOW_DEPTH),
        .BG_COUNT_WIDTH (BG_COUNT_WIDTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic void reset_model();
        frames_seen  = '0;
        last_level   = '0;
        bg_sum       = 0;
        bg_frames    = 0;
        bg_avg       = '0;
        history_fill = 0;
        rise_limit   = ENV_THR_RESET;
        loud_margin  = NOISE_OFF_RESET;
        loud_needed  = ALARM_CNT_RESET;
    endfunction

    function automatic verdict_t judge_frame(input logic signed [LEVEL_W-1:0] lvl);
        verdict_t v;
        int rise;
        int floor_lvl;
        int margin;
        int n_loud;
        v = '0;
        if (frames_seen < WARMUP_FRAMES) begin
            frames_seen = frames_seen + 1'b1;
            last_level  = lvl;
            v.bg        = bg_avg;
            return v;
        end
        rise       = int'(lvl) - int'(last_level);
        last_level = lvl;
        if (rise < int'(rise_limit) && bg_frames < BG_COUNT_MAX) begin
            bg_frames++;
            bg_sum += longint'(lvl);
            bg_avg = LEVEL_W'(bg_sum / bg_frames);
        end
        floor_lvl = (bg_avg < AVG_SPLIT) ? int'(FLOOR_QUIET) : int'(FLOOR_LOUD);
        if (history_fill >= WINDOW_DEPTH) begin
            for (int i = 1; i < WINDOW_DEPTH; i++)
                history[i-1] = history[i];
            history[WINDOW_DEPTH-1] = lvl;
        end else begin
            history[history_fill] = lvl;
            history_fill++;
        end
        margin = int'(bg_avg) + int'(loud_margin);
        n_loud = 0;
        for (int i = 0; i < history_fill; i++)
            if (int'(history[i]) > margin && int'(history[i]) > floor_lvl)
                n_loud++;
        if (n_loud >= int'(loud_needed)) begin
            history_fill = 0;
            v.alarm      = 1'b1;
        end
        v.bg   = bg_avg;
        v.loud = (n_loud > 15) ? 4'd15 : LOUD_OUT_W'(n_loud);
        return v;
    endfunction

    // quiet scene around a base level, short loud bursts, a little raw noise
    function automatic logic signed [LEVEL_W-1:0] next_scene_level();
        int lv;
        if ($urandom_range(99) < 3)
            return LEVEL_W'($urandom);
        if (burst_left > 0) begin
            burst_left--;
            lv = scene_base + int'($urandom_range(12800, 2560));
        end else begin
            if ($urandom_range(99) < 4)
                burst_left = $urandom_range(8, 1);
            if ($urandom_range(99) < 2)
                scene_base = $urandom_range(65 * 256, 35 * 256);
            lv = scene_base + int'($urandom_range(1536, 0)) - 768;
        end
        if (lv > 32767)
            lv = 32767;
        return LEVEL_W'(lv);
    endfunction

    task automatic note_mismatch(input string what, input verdict_t want, input verdict_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display(
                "mismatch at cycle %0d, %s: exp alarm %0d bg %0d loud %0d, got %0d %0d %0d",
                cycles, what, want.alarm, want.bg, want.loud, got.alarm, got.bg, got.loud);
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin : check_words
        verdict_t got;
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(verdict_t)-1:0];
            if (pending_verdicts.size() == 0) begin
                note_mismatch("word with nothing pending", '0, got);
            end else begin
                want = pending_verdicts.pop_front();
                if (got.alarm !== want.alarm || got.bg !== want.bg || got.loud !== want.loud)
                    note_mismatch("field differs", want, got);
                if (got.alarm === 1'b1)
                    alarms_seen++;
                if (got.loud != '0)
                    loud_frames++;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still pending", cycles,
                     pending_verdicts.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_level(input logic signed [LEVEL_W-1:0] lvl);
        @(negedge aclk);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= lvl;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_verdicts.push_back(judge_frame(lvl));
        frames_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_ENV_THRESHOLD: rise_limit  = val;
            REG_NOISE_OFFSET:  loud_margin = val;
            REG_ALARM_COUNT:   loud_needed = val[ACNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [THR_W-1:0] thr, input logic [THR_W-1:0] off,
                                 input logic [ACNT_W-1:0] cnt);
        set_register(REG_ENV_THRESHOLD, thr);
        set_register(REG_NOISE_OFFSET, off);
        set_register(REG_ALARM_COUNT, THR_W'(cnt));
        settings_used++;
    endtask

    task automatic test_warmup();
        send_level(16'sh7FFF);
        send_level(16'sh8000);
        send_level(16'sh0000);
        send_level(16'sd10240);
    endtask

    task automatic test_level_edges();
        logic signed [LEVEL_W-1:0] edges [17];
        edges = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh0000,
                  FLOOR_QUIET, FLOOR_QUIET + 16'sd1, FLOOR_LOUD, FLOOR_LOUD + 16'sd1,
                  AVG_SPLIT - 16'sd1, AVG_SPLIT,
                  AVG_SPLIT + 16'sd1280, AVG_SPLIT + 16'sd2559,
                  -16'sd1, 16'sd1, 16'sh4000, 16'sh5555, 16'shAAAA};
        foreach (edges[i])
            send_level(edges[i]);
    endtask

    task automatic test_scenes();
        for (int phase = 0; phase < SCENE_PHASES; phase++) begin
            wait_for_results();
            case (phase)
                0: begin
                    apply_setting(ENV_THR_RESET, NOISE_OFF_RESET, ALARM_CNT_RESET);
                    // spare index must leave every register alone
                    set_register(REG_SPARE, '1);
                end
                1: apply_setting('0, '0, 4'd1);
                2: apply_setting('1, '1, 4'd15);
                3: apply_setting(THR_W'($urandom_range(3840)), THR_W'($urandom_range(3840)),
                                 4'd0);
                default: apply_setting(THR_W'($urandom_range(3840)),
                                       THR_W'($urandom_range(3840)),
                                       ACNT_W'($urandom_range(15, 1)));
            endcase
            if (phase < 3) begin
                send_gap_pct = 8;
                stall_pct    = 56;
            end else if (phase < 6) begin
                send_gap_pct = 56;
                stall_pct    = 8;
            end else begin
                send_gap_pct = 0;
                stall_pct    = 0;
            end
            for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
                if ($urandom_range(199) == 0)
                    wait_for_results();
                send_level(next_scene_level());
            end
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_ENV_THRESHOLD;
        cfg_wdata     = '0;
        cycles        = 0;
        mismatches    = 0;
        frames_sent   = 0;
        alarms_seen   = 0;
        loud_frames   = 0;
        settings_used = 1;
        send_gap_pct  = 8;
        stall_pct     = 56;
        scene_base    = 45 * 256;
        burst_left    = 0;
        reset_model();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_warmup();
        test_level_edges();
        test_scenes();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("%0d frame words sent under %0d register settings, three stall patterns",
                 frames_sent, settings_used);
        $display("%0d alarms, %0d words with loud entries, %0d mismatches, %0d left pending",
                 alarms_seen, loud_frames, mismatches, pending_verdicts.size());
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/sla_pkg.sv
sv/sla_ram.sv
sv/sla_div.sv
sv/sound_level_alarm_detector_core.sv
tb/sv/testbench.sv
